>>> src/assert_macros.svh
// Assertion helpers for the RTL; only odo_ctrl.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every rising edge outside of reset.
`define ODO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a rising edge outside of reset.
`define ODO_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/odo_pkg.sv
package odo_pkg;

    localparam int COUNT_BITS   = 12;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    localparam int CNT_FIELD_W = 12;
    localparam int DIST_W      = 24;
    localparam int TURN_W      = 32;
    localparam int POS_W       = 32;
    localparam int ANG_W       = 32;
    localparam int HEAD_W      = 16;

    // Travel sum is (lc + rc) * dist_per_count, mean drops 9 bits.
    localparam int SUM_W     = COUNT_BITS + 2 + DIST_W;
    localparam int MEAN_W    = SUM_W - 9;
    localparam int MUL_A_W   = MEAN_W;
    localparam int MUL_B_W   = TURN_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 88;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIST = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TURN = 2'd1;

    localparam logic [DIST_W-1:0] DIST_RESET   = 24'd38319;
    localparam logic [TURN_W-1:0] TURN_RESET   = 32'd0;
    localparam logic [ANG_W-1:0]  QUARTER_TURN = 32'h4000_0000;
    localparam logic [ANG_W-1:0]  QUAD_ROUND   = 32'h2000_0000;
    localparam logic signed [POS_W-1:0] CORDIC_GAIN = 32'sd652032874;

    typedef enum logic [1:0] {
        MUL_TURN,
        MUL_SUM,
        MUL_COS,
        MUL_SIN
    } t_mul_sel;

    typedef struct packed {
        logic              capture;
        logic              pose_clear;
        logic              mul_en;
        t_mul_sel          mul_sel;
        logic              head_add;
        logic              mean_load;
        logic              cordic_step;
        logic [STEP_W-1:0] step;
        logic              x_add;
        logic              y_add;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic reset_req;
        logic out_busy;
    } t_status;

    // atan(2^-i) in 2^-32 turn, truncated.
    function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] idx);
        logic [ANG_W-1:0] a;
        unique case (idx)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933405;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335086;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41721;
            5'd15:   a = 32'd20860;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2607;
            5'd19:   a = 32'd1303;
            5'd20:   a = 32'd651;
            5'd21:   a = 32'd325;
            5'd22:   a = 32'd162;
            5'd23:   a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

>>> src/odo_ctrl.sv
module odo_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  odo_pkg::t_status i_status,
    output logic             o_s_tready,
    output odo_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MULH,
        S_HEAD,
        S_MEAN,
        S_CORD,
        S_MULX,
        S_ADDX,
        S_ADDY,
        S_OUT
    } t_state;

    t_state r_state;
    logic [odo_pkg::STEP_W-1:0] r_step;
    logic w_last_step;

    assign w_last_step = (r_step == odo_pkg::STEP_W'(odo_pkg::CORDIC_STEPS - 1));
    assign o_s_tready  = (r_state == S_IDLE);

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = odo_pkg::MUL_TURN;
        o_cmd.step    = r_step;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_s_tvalid;
            end
            S_MULH: begin
                o_cmd.pose_clear = i_status.reset_req;
                o_cmd.mul_en     = !i_status.reset_req;
                o_cmd.mul_sel    = odo_pkg::MUL_TURN;
            end
            S_HEAD: begin
                o_cmd.head_add = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = odo_pkg::MUL_SUM;
            end
            S_MEAN: begin
                o_cmd.mean_load = 1'b1;
            end
            S_CORD: begin
                o_cmd.cordic_step = 1'b1;
            end
            S_MULX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = odo_pkg::MUL_COS;
            end
            S_ADDX: begin
                o_cmd.x_add   = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = odo_pkg::MUL_SIN;
            end
            S_ADDY: begin
                o_cmd.y_add = 1'b1;
            end
            S_OUT: begin
                o_cmd.out_load = !i_status.out_busy;
            end
            default: begin
                o_cmd.capture = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_MULH;
                    end
                end
                S_MULH: begin
                    r_state <= i_status.reset_req ? S_OUT : S_HEAD;
                end
                S_HEAD: begin
                    r_state <= S_MEAN;
                end
                S_MEAN: begin
                    r_state <= S_CORD;
                    r_step  <= '0;
                end
                S_CORD: begin
                    if (w_last_step) begin
                        r_step  <= '0;
                        r_state <= S_MULX;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_MULX: begin
                    r_state <= S_ADDX;
                end
                S_ADDX: begin
                    r_state <= S_ADDY;
                end
                S_ADDY: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_status.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "assert_macros.svh"

    `ODO_ASSERT(a_step_idle, i_clk, i_rst_n, (r_state != S_CORD) |-> (r_step == '0), "step counter left nonzero outside the rotation loop")
    `ODO_ASSERT_NEVER(a_load_busy, i_clk, i_rst_n, o_cmd.out_load && i_status.out_busy, "result loaded over an untaken result")
    `ODO_ASSERT(a_capture_next, i_clk, i_rst_n, o_cmd.capture |=> (r_state == S_MULH), "captured item did not start processing")

endmodule

>>> src/odo_dp.sv
module odo_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  odo_pkg::t_cmd                         i_cmd,
    output odo_pkg::t_status                      o_status,
    input  logic                                  i_cfg_we,
    input  logic [odo_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [odo_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic [odo_pkg::IN_DATA_W-1:0]         i_s_tdata,
    input  logic [odo_pkg::IN_USER_W-1:0]         i_s_tuser,
    input  logic                                  i_m_tready,
    output logic                                  o_m_tvalid,
    output logic [odo_pkg::OUT_DATA_W-1:0]        o_m_tdata
);

    localparam int CW = odo_pkg::COUNT_BITS;
    localparam int FW = odo_pkg::CNT_FIELD_W;
    localparam int PW = odo_pkg::POS_W;

    // Configuration.
    logic [odo_pkg::DIST_W-1:0] r_dist;
    logic [odo_pkg::TURN_W-1:0] r_turn;

    // Captured item.
    logic signed [CW:0] r_lc;
    logic signed [CW:0] r_rc;
    logic               r_rst_req;

    // Pose.
    logic signed [PW-1:0]            r_x;
    logic signed [PW-1:0]            r_y;
    logic [odo_pkg::ANG_W-1:0]       r_heading;
    logic                            r_sat;

    // Working registers.
    logic signed [odo_pkg::PROD_W-1:0] r_prod;
    logic signed [odo_pkg::MEAN_W-1:0] r_mean;
    logic [1:0]                        r_quad;
    logic signed [PW-1:0]              r_cx;
    logic signed [PW-1:0]              r_cy;
    logic signed [odo_pkg::ANG_W-1:0]  r_cz;

    // Output register.
    logic                               r_out_valid;
    logic [odo_pkg::OUT_DATA_W-1:0]     r_out_data;

    logic signed [CW:0]                  w_lc_mag;
    logic signed [CW:0]                  w_rc_mag;
    logic signed [CW+1:0]                w_diff;
    logic signed [CW+1:0]                w_csum;
    logic signed [odo_pkg::MUL_A_W-1:0]  w_mul_a;
    logic signed [odo_pkg::MUL_B_W-1:0]  w_mul_b;
    logic signed [odo_pkg::MUL_B_W-1:0]  w_xe;
    logic signed [odo_pkg::MUL_B_W-1:0]  w_ye;
    logic signed [odo_pkg::MUL_B_W-1:0]  w_cos;
    logic signed [odo_pkg::MUL_B_W-1:0]  w_sin;
    logic [odo_pkg::SUM_W-1:0]           w_mean_rnd;
    logic [odo_pkg::ANG_W-1:0]           w_qsum;
    logic signed [PW-1:0]                w_xs;
    logic signed [PW-1:0]                w_ys;
    logic signed [odo_pkg::ANG_W-1:0]    w_atan;
    logic signed [odo_pkg::PROD_W-1:0]   w_prod_rnd;
    logic signed [PW-1:0]                w_delta;
    logic signed [PW-1:0]                w_pose_in;
    logic signed [PW:0]                  w_pose_sum;
    logic                                w_ovf;
    logic signed [PW-1:0]                w_pose_out;

    assign w_lc_mag = $signed({1'b0, i_s_tdata[CW-1:0]});
    assign w_rc_mag = $signed({1'b0, i_s_tdata[FW+CW-1:FW]});
    assign w_diff   = {r_rc[CW], r_rc} - {r_lc[CW], r_lc};
    assign w_csum   = {r_rc[CW], r_rc} + {r_lc[CW], r_lc};

    // Quadrant rotation of the CORDIC result.
    assign w_xe = odo_pkg::MUL_B_W'(r_cx);
    assign w_ye = odo_pkg::MUL_B_W'(r_cy);

    always_comb begin
        unique case (r_quad)
            2'd0: begin
                w_cos = w_xe;
                w_sin = w_ye;
            end
            2'd1: begin
                w_cos = -w_ye;
                w_sin = w_xe;
            end
            2'd2: begin
                w_cos = -w_xe;
                w_sin = -w_ye;
            end
            default: begin
                w_cos = w_ye;
                w_sin = -w_xe;
            end
        endcase
    end

    // One shared signed multiplier.
    always_comb begin
        unique case (i_cmd.mul_sel)
            odo_pkg::MUL_TURN: begin
                w_mul_a = odo_pkg::MUL_A_W'(w_diff);
                w_mul_b = $signed({1'b0, r_turn});
            end
            odo_pkg::MUL_SUM: begin
                w_mul_a = odo_pkg::MUL_A_W'(w_csum);
                w_mul_b = odo_pkg::MUL_B_W'($signed({1'b0, r_dist}));
            end
            odo_pkg::MUL_COS: begin
                w_mul_a = r_mean;
                w_mul_b = w_cos;
            end
            default: begin
                w_mul_a = r_mean;
                w_mul_b = w_sin;
            end
        endcase
    end

    assign w_mean_rnd = r_prod[odo_pkg::SUM_W-1:0] + odo_pkg::SUM_W'(256);
    assign w_qsum     = r_heading + odo_pkg::QUAD_ROUND;

    assign w_xs   = r_cx >>> i_cmd.step;
    assign w_ys   = r_cy >>> i_cmd.step;
    assign w_atan = $signed(odo_pkg::atan_turn(5'(i_cmd.step)));

    // Round the projected travel and add it to x or y with clamping.
    assign w_prod_rnd = r_prod + $signed(odo_pkg::PROD_W'(64'd1 << 29));
    assign w_delta    = w_prod_rnd[PW+29:30];
    assign w_pose_in  = i_cmd.y_add ? r_y : r_x;
    assign w_pose_sum = {w_pose_in[PW-1], w_pose_in} + {w_delta[PW-1], w_delta};
    assign w_ovf      = w_pose_sum[PW] != w_pose_sum[PW-1];

    always_comb begin
        if (!w_ovf) begin
            w_pose_out = w_pose_sum[PW-1:0];
        end else if (w_pose_sum[PW]) begin
            w_pose_out = {1'b1, {(PW-1){1'b0}}};
        end else begin
            w_pose_out = {1'b0, {(PW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= odo_pkg::DIST_RESET;
            r_turn <= odo_pkg::TURN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                odo_pkg::CFG_DIST: r_dist <= i_cfg_wdata[odo_pkg::DIST_W-1:0];
                odo_pkg::CFG_TURN: r_turn <= i_cfg_wdata[odo_pkg::TURN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= '0;
            r_y       <= '0;
            r_heading <= odo_pkg::QUARTER_TURN;
            r_sat     <= 1'b0;
            r_rst_req <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_lc      <= i_s_tdata[FW*2] ? -w_lc_mag : w_lc_mag;
                r_rc      <= i_s_tdata[FW*2+1] ? -w_rc_mag : w_rc_mag;
                r_rst_req <= i_s_tuser[0];
                r_sat     <= 1'b0;
            end
            if (i_cmd.pose_clear) begin
                r_x       <= '0;
                r_y       <= '0;
                r_heading <= odo_pkg::QUARTER_TURN;
            end
            if (i_cmd.mul_en) begin
                r_prod <= w_mul_a * w_mul_b;
            end
            if (i_cmd.head_add) begin
                r_heading <= r_heading + r_prod[odo_pkg::ANG_W-1:0];
            end
            if (i_cmd.mean_load) begin
                r_mean <= $signed(w_mean_rnd[odo_pkg::SUM_W-1:9]);
                r_quad <= w_qsum[odo_pkg::ANG_W-1:odo_pkg::ANG_W-2];
                r_cz   <= $signed(r_heading - {w_qsum[odo_pkg::ANG_W-1:odo_pkg::ANG_W-2],
                                               30'd0});
                r_cx   <= odo_pkg::CORDIC_GAIN;
                r_cy   <= '0;
            end
            if (i_cmd.cordic_step) begin
                if (!r_cz[odo_pkg::ANG_W-1]) begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - w_atan;
                end else begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + w_atan;
                end
            end
            if (i_cmd.x_add) begin
                r_x   <= w_pose_out;
                r_sat <= r_sat | w_ovf;
            end
            if (i_cmd.y_add) begin
                r_y   <= w_pose_out;
                r_sat <= r_sat | w_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
            r_out_data  <= {7'd0, r_sat,
                            r_heading[odo_pkg::ANG_W-1:odo_pkg::ANG_W-odo_pkg::HEAD_W],
                            r_y, r_x};
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.reset_req = r_rst_req;
    assign o_status.out_busy  = r_out_valid && !i_m_tready;
    assign o_m_tvalid         = r_out_valid;
    assign o_m_tdata          = r_out_data;

endmodule

>>> src/diff_drive_odometry.sv
// A motion tick passes through the heading update, the mean travel, the
// iterative CORDIC rotator and the two projections; a pose-reset tick goes
// straight to the output load. The rotator runs one micro-rotation per cycle;
// a new tick is taken only once the last one has been loaded for output.
// Reset (i_rst_n low, synchronous): pose returns to the origin facing a
// quarter turn, both scale registers take their default values.
module diff_drive_odometry (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration writes: index 0 is dist_per_count, index 1 turn_per_count.
    input  logic                                i_cfg_we,
    input  logic [odo_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [odo_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // Encoder tick stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // left_count [11:0], right_count [23:12], left_reverse [24],
    // right_reverse [25], zero [31:26].
    input  logic [odo_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // reset_pose [0].
    input  logic [odo_pkg::IN_USER_W-1:0]       i_s_tuser,
    // Pose stream.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // x_pos [31:0], y_pos [63:32], heading [79:64], saturated [80],
    // zero [87:81].
    output logic [odo_pkg::OUT_DATA_W-1:0]      o_m_tdata
);

    // The controller walks each motion tick through the heading update, the mean
    // travel, the CORDIC rotation and the two projections. It drives the
    // datapath purely through a command word and reads back a small status
    // word (pose-reset request and output-slot occupancy).
    odo_pkg::t_cmd    w_cmd;
    odo_pkg::t_status w_status;

    odo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (w_status),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the pose, the scale registers, one shared
    // multiplier, the CORDIC rotator and the output register. A finished
    // result waits in the output register while the next tick is taken in;
    // only the final load stalls if that register is still occupied.
    odo_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // The block only decodes register indexes 0 and 1. Writes to the two
    // spare indexes must leave both scale registers untouched.
    localparam logic [odo_pkg::CFG_ADDR_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [odo_pkg::CFG_ADDR_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [11:0]  COUNT_MAX  = 12'hFFF;
    localparam logic [31:0]  DIST_MAX   = 32'h00FF_FFFF;
    localparam logic [31:0]  TURN_MAX   = 32'hFFFF_FFFF;
    localparam int           PHASES     = 6;
    localparam int           PHASE_TICKS = 300;
    // Margin that covers anything still in flight.
    localparam int           SETTLE_CYCLES = 32;
    // About 1800 ticks, stretched by idling, stay far below this.
    localparam int unsigned  CYCLE_LIMIT = 600000;
    localparam longint       POS_MAX = 64'sd2147483647;
    localparam longint       POS_MIN = -64'sd2147483648;

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32 and truncated.
    localparam int ATAN_TURN [24] = '{
        536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335086, 667544, 333772,
        166886, 83443, 41721, 20860, 10430, 5215,
        2607, 1303, 651, 325, 162, 81
    };

    typedef struct packed {
        logic [11:0] left_count;
        logic [11:0] right_count;
        logic        left_reverse;
        logic        right_reverse;
        logic        reset_pose;
    } t_tick;

    typedef struct packed {
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic [15:0]        heading;
        logic               saturated;
    } t_pose;

    typedef enum logic {
        ROW_TICK,
        ROW_WRITE
    } t_row_kind;

    // One line of the directed plan: either a register write or a tick that is
    // sent reps times. Where the result is obvious it is typed in as known_pose.
    typedef struct packed {
        t_row_kind                        kind;
        logic [4:0]                       reps;
        logic [odo_pkg::CFG_ADDR_W-1:0]   reg_idx;
        logic [31:0]                      reg_val;
        t_tick                            tick;
        logic                             typed;
        t_pose                            known_pose;
    } t_row;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    localparam int PLAN_ROWS = 15;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [odo_pkg::CFG_ADDR_W-1:0]   cfg_addr = '0;
    logic [odo_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [odo_pkg::IN_DATA_W-1:0]    s_tdata = '0;
    logic [odo_pkg::IN_USER_W-1:0]    s_tuser = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [odo_pkg::OUT_DATA_W-1:0]   m_tdata;

    // Shadow of the block: pose and scale registers as the block should hold them.
    logic signed [31:0]      est_x;
    logic signed [31:0]      est_y;
    logic [31:0]             est_heading;
    logic [31:0]             dist_reg;
    logic [31:0]             turn_reg;

    t_pose                   pending_poses[$];
    int                      mismatches = 0;
    int                      send_idle_pct = 0;
    int                      recv_stall_pct = 0;
    t_row                    plan [0:PLAN_ROWS-1];

    diff_drive_odometry dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Cosine and sine of a binary angle in Q2.30. The angle is first folded
    // to the nearest quarter turn so that the micro-rotations only have to
    // cover plus or minus an eighth of a turn; the quadrant is put back last.
    task automatic rotate_unit(input logic [31:0] angle, output longint cos_q30,
                               output longint sin_q30);
        logic [31:0] rounded;
        logic [1:0]  quad;
        logic [31:0] residual;
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        int          steps;
        int          i;
        rounded  = angle + odo_pkg::QUAD_ROUND;
        quad     = rounded[31:30];
        residual = angle - {quad, 30'd0};
        z        = longint'($signed(residual));
        x        = longint'(odo_pkg::CORDIC_GAIN);
        y        = 0;
        steps    = (odo_pkg::CORDIC_STEPS > 24) ? 24 : odo_pkg::CORDIC_STEPS;
        for (i = 0; i < steps; i++) begin
            // Both shifts use the values from before this micro-rotation.
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURN[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURN[i];
            end
        end
        case (quad)
            2'd0: begin cos_q30 = x;  sin_q30 = y;  end
            2'd1: begin cos_q30 = -y; sin_q30 = x;  end
            2'd2: begin cos_q30 = -x; sin_q30 = -y; end
            default: begin cos_q30 = y; sin_q30 = -x; end
        endcase
    endtask

    function automatic logic signed [31:0] clamp_add(input logic signed [31:0] pos,
                                                     input longint delta,
                                                     output logic clipped);
        longint sum;
        sum     = longint'(pos) + delta;
        clipped = 1'b0;
        if (sum > POS_MAX) begin
            clipped = 1'b1;
            sum     = POS_MAX;
        end else if (sum < POS_MIN) begin
            clipped = 1'b1;
            sum     = POS_MIN;
        end
        return sum[31:0];
    endfunction

    // Moves the shadow pose by one tick and returns the pose the block reports.
    task automatic advance_pose(input t_tick t, output t_pose pose);
        longint lc;
        longint rc;
        longint turn_prod;
        longint travel;
        longint mean;
        longint c;
        longint s;
        longint dx;
        longint dy;
        logic   clip_x;
        logic   clip_y;
        pose.saturated = 1'b0;
        if (t.reset_pose) begin
            est_x       = '0;
            est_y       = '0;
            est_heading = odo_pkg::QUARTER_TURN;
        end else begin
            lc = longint'(t.left_count) & ((64'sd1 <<< odo_pkg::COUNT_BITS) - 1);
            rc = longint'(t.right_count) & ((64'sd1 <<< odo_pkg::COUNT_BITS) - 1);
            if (t.left_reverse) lc = -lc;
            if (t.right_reverse) rc = -rc;
            // Turn first: only the low 32 bits matter, so the heading wraps per turn.
            turn_prod   = (rc - lc) * longint'(turn_reg);
            est_heading = est_heading + turn_prod[31:0];
            // Mean travel of both wheels, from 2^-16 mm to 1/256 mm, rounded half up.
            travel = (lc + rc) * longint'(dist_reg);
            mean   = (travel + 64'sd256) >>> 9;
            rotate_unit(est_heading, c, s);
            dx     = (mean * c + (64'sd1 <<< 29)) >>> 30;
            dy     = (mean * s + (64'sd1 <<< 29)) >>> 30;
            est_x  = clamp_add(est_x, dx, clip_x);
            est_y  = clamp_add(est_y, dy, clip_y);
            pose.saturated = clip_x | clip_y;
        end
        pose.x_pos   = est_x;
        pose.y_pos   = est_y;
        pose.heading = est_heading[31:16];
    endtask

    function automatic t_row tick_row(input logic [11:0] lc, input logic [11:0] rc,
                                      input logic lrev, input logic rrev,
                                      input logic clear, input int reps);
        t_row r;
        r                    = '0;
        r.kind               = ROW_TICK;
        r.reps               = reps[4:0];
        r.tick.left_count    = lc;
        r.tick.right_count   = rc;
        r.tick.left_reverse  = lrev;
        r.tick.right_reverse = rrev;
        r.tick.reset_pose    = clear;
        return r;
    endfunction

    function automatic t_row write_row(input logic [odo_pkg::CFG_ADDR_W-1:0] idx,
                                       input logic [31:0] val);
        t_row r;
        r         = '0;
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // The pose is known without arithmetic: at the origin, facing a quarter turn.
    function automatic t_row at_origin(input t_row r);
        t_row o;
        o                      = r;
        o.typed                = 1'b1;
        o.known_pose.x_pos     = '0;
        o.known_pose.y_pos     = '0;
        o.known_pose.heading   = odo_pkg::QUARTER_TURN[31:16];
        o.known_pose.saturated = 1'b0;
        return o;
    endfunction

    // Most random ticks come in shapes that a robot produces (straight runs,
    // spins on the spot, one wheel held, slow creeping); the rest is fully
    // random. Pose resets are kept rare so that positions can run into the
    // saturation limits.
    function automatic t_tick random_tick();
        t_tick t;
        int    pick;
        pick            = $urandom_range(0, 99);
        t.left_count    = 12'($urandom);
        t.right_count   = 12'($urandom);
        t.left_reverse  = 1'($urandom);
        t.right_reverse = 1'($urandom);
        t.reset_pose    = 1'b0;
        if (pick < 3) begin
            t.reset_pose = 1'b1;
        end else if (pick < 23) begin
            t.left_count  = 12'($urandom_range(0, 15));
            t.right_count = 12'($urandom_range(0, 15));
        end else if (pick < 40) begin
            t.right_count   = t.left_count;
            t.right_reverse = t.left_reverse;
        end else if (pick < 50) begin
            t.right_count   = t.left_count;
            t.right_reverse = ~t.left_reverse;
        end else if (pick < 58) begin
            if ($urandom_range(0, 1) == 0) t.left_count = '0;
            else t.right_count = '0;
        end
        return t;
    endfunction

    task automatic set_idling(input t_idle_mode mode);
        send_idle_pct  = (mode == IDLE_SENDER)   ? 70 : (mode == IDLE_BOTH) ? 6 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 70 : (mode == IDLE_BOTH) ? 6 : 0;
    endtask

    // Offers one tick, with random idle cycles in front of it, and holds it
    // until the transfer happens. Valid is left high afterwards so that
    // back-to-back ticks follow without a gap.
    task automatic send_tick(input t_tick t, input logic typed, input t_pose known_pose);
        t_pose est;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, t.right_reverse, t.left_reverse, t.right_count, t.left_count};
        s_tuser  <= t.reset_pose;
        do @(posedge clk); while (!s_tready);
        advance_pose(t, est);
        pending_poses.push_back(typed ? known_pose : est);
    endtask

    task automatic go_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (pending_poses.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [odo_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == odo_pkg::CFG_DIST) dist_reg = {8'd0, val[odo_pkg::DIST_W-1:0]};
        else if (idx == odo_pkg::CFG_TURN) turn_reg = val;
    endtask

    function automatic void check_pose(input logic [odo_pkg::OUT_DATA_W-1:0] beat);
        t_pose got;
        t_pose want;
        got.x_pos     = beat[31:0];
        got.y_pos     = beat[63:32];
        got.heading   = beat[79:64];
        got.saturated = beat[80];
        if (pending_poses.size() == 0) begin
            $error("pose transfer with no tick outstanding: x=%0d y=%0d",
                   got.x_pos, got.y_pos);
            mismatches++;
        end else begin
            want = pending_poses.pop_front();
            if (got.x_pos !== want.x_pos) begin
                $error("x_pos: expected %0d, got %0d", want.x_pos, got.x_pos);
                mismatches++;
            end
            if (got.y_pos !== want.y_pos) begin
                $error("y_pos: expected %0d, got %0d", want.y_pos, got.y_pos);
                mismatches++;
            end
            if (got.heading !== want.heading) begin
                $error("heading: expected 0x%04h, got 0x%04h", want.heading, got.heading);
                mismatches++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
                mismatches++;
            end
        end
    endfunction

    // Pose side: the values seen here are the ones from before the edge, so a
    // transfer is exactly what the block sees as one. Ready is redrawn every
    // cycle, which spreads stalls over every phase of the output handshake.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) check_pose(m_tdata);
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // A hung handshake ends the run here.
    initial begin
        int unsigned waited;
        waited = 0;
        while (waited < CYCLE_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int          r;
        int          n;
        int          p;
        t_tick       t;
        t_pose       none;
        logic [31:0] dist_val;
        logic [31:0] turn_val;
        t_idle_mode  mode;

        none        = '0;
        est_x       = '0;
        est_y       = '0;
        est_heading = odo_pkg::QUARTER_TURN;
        dist_reg    = {8'd0, odo_pkg::DIST_RESET};
        turn_reg    = odo_pkg::TURN_RESET;

        // Directed part. At reset the turn gain is zero, so the heading holds
        // until the gain is written further down.
        plan = '{
            // Nothing moves: the pose stays at reset.
            at_origin(tick_row(12'd0, 12'd0, 1'b0, 1'b0, 1'b0, 1)),
            // Pose reset ignores full-scale counts.
            at_origin(tick_row(COUNT_MAX, COUNT_MAX, 1'b1, 1'b1, 1'b1, 1)),
            // Spin on the spot: the wheel travels cancel.
            tick_row(COUNT_MAX, COUNT_MAX, 1'b0, 1'b1, 1'b0, 1),
            write_row(odo_pkg::CFG_DIST, DIST_MAX),
            // Full speed ahead along +y until the position clips.
            tick_row(COUNT_MAX, COUNT_MAX, 1'b0, 1'b0, 1'b0, 9),
            at_origin(tick_row(12'd0, 12'd0, 1'b0, 1'b0, 1'b1, 1)),
            // Full speed backwards until the negative limit clips.
            tick_row(COUNT_MAX, COUNT_MAX, 1'b1, 1'b1, 1'b0, 9),
            write_row(odo_pkg::CFG_TURN, TURN_MAX),
            tick_row(COUNT_MAX, COUNT_MAX, 1'b0, 1'b1, 1'b0, 1),
            // A quarter turn per count: three counts wrap the heading past zero.
            write_row(odo_pkg::CFG_TURN, odo_pkg::QUARTER_TURN),
            tick_row(12'd0, 12'd3, 1'b0, 1'b0, 1'b0, 1),
            // Writes to spare indexes must change nothing.
            write_row(CFG_SPARE_A, 32'h0000_0000),
            write_row(CFG_SPARE_B, 32'hFFFF_FFFF),
            tick_row(12'd5, 12'd9, 1'b1, 1'b0, 1'b0, 1),
            at_origin(tick_row(COUNT_MAX, 12'd0, 1'b0, 1'b1, 1'b1, 1))
        };

        set_idling(IDLE_NONE);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < PLAN_ROWS; r++) begin
            if (plan[r].kind == ROW_WRITE) begin
                go_quiet();
                wait_idle();
                write_reg(plan[r].reg_idx, plan[r].reg_val);
            end else begin
                for (n = 0; n < plan[r].reps; n++)
                    send_tick(plan[r].tick, plan[r].typed, plan[r].known_pose);
            end
        end

        // Random part: each phase brings its own scale settings and handshake
        // pressure. The settings include both extremes of both registers.
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    dist_val = {8'd0, odo_pkg::DIST_RESET};
                    turn_val = 32'h0008_0000;
                    mode     = IDLE_NONE;
                end
                1: begin
                    dist_val = 32'd1;
                    turn_val = 32'd0;
                    mode     = IDLE_SENDER;
                end
                2: begin
                    dist_val = DIST_MAX;
                    turn_val = TURN_MAX;
                    mode     = IDLE_RECEIVER;
                end
                3: begin
                    dist_val = $urandom_range(1, DIST_MAX);
                    turn_val = $urandom;
                    mode     = IDLE_BOTH;
                end
                4: begin
                    dist_val = $urandom_range(1, 65535);
                    turn_val = $urandom_range(0, 32'h00FF_FFFF);
                    mode     = IDLE_SENDER;
                end
                default: begin
                    dist_val = $urandom_range(1, DIST_MAX);
                    turn_val = $urandom;
                    mode     = IDLE_NONE;
                end
            endcase
            go_quiet();
            wait_idle();
            write_reg(odo_pkg::CFG_DIST, dist_val);
            write_reg(odo_pkg::CFG_TURN, turn_val);
            write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
            set_idling(mode);
            for (n = 0; n < PHASE_TICKS; n++) begin
                t = random_tick();
                send_tick(t, 1'b0, none);
            end
        end

        go_quiet();
        wait_idle();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
